// ----- rtl/ckre_pkg.sv -----
// ckre_pkg: shared types and constants for the color-key run extractor.
// Holds the configuration register layout, register indexes and format codes.
// No dependencies.
package ckre_pkg;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_KEY_COLOR    = 2'd0,
    REG_PIXEL_FORMAT = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_idx_t;

  // Pixel format codes
  localparam logic [1:0] FMT_PAL8  = 2'd0;
  localparam logic [1:0] FMT_RGB16 = 2'd1;
  localparam logic [1:0] FMT_RGB24 = 2'd2;
  localparam logic [1:0] FMT_RGB32 = 2'd3;

  // Word kind codes on the input channel
  localparam logic KIND_PIXEL     = 1'b0;
  localparam logic KIND_PAL_WRITE = 1'b1;

  localparam int KEY_W  = 24;
  localparam int FMT_W  = 2;
  localparam int SIZE_W = 13;

  localparam logic [KEY_W-1:0]  KEY_RESET    = 24'hFF00FF;  // magenta
  localparam logic [FMT_W-1:0]  FMT_RESET    = FMT_RGB24;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd4096;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd4096;

  typedef struct packed {
    logic [KEY_W-1:0]  key_color;
    logic [FMT_W-1:0]  pixel_format;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
  } cfg_t;

endpackage

// ----- rtl/ckre_cfg_regs.sv -----
// ckre_cfg_regs: APB-style register file for the color-key run extractor.
// Holds key color, pixel format and image size; presents them as a cfg_t.
// Depends on ckre_pkg.
module ckre_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output ckre_pkg::cfg_t    cfg
);

  ckre_pkg::cfg_t   cfg_r;
  ckre_pkg::reg_idx_t idx;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = ckre_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_color    <= ckre_pkg::KEY_RESET;
      cfg_r.pixel_format <= ckre_pkg::FMT_RESET;
      cfg_r.image_width  <= ckre_pkg::WIDTH_RESET;
      cfg_r.image_height <= ckre_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        ckre_pkg::REG_KEY_COLOR:    cfg_r.key_color    <= cfg_pwdata[ckre_pkg::KEY_W-1:0];
        ckre_pkg::REG_PIXEL_FORMAT: cfg_r.pixel_format <= cfg_pwdata[ckre_pkg::FMT_W-1:0];
        ckre_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_pwdata[ckre_pkg::SIZE_W-1:0];
        ckre_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_pwdata[ckre_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ckre_pkg::REG_KEY_COLOR:    cfg_prdata = 32'(cfg_r.key_color);
      ckre_pkg::REG_PIXEL_FORMAT: cfg_prdata = 32'(cfg_r.pixel_format);
      ckre_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 32'(cfg_r.image_width);
      ckre_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 32'(cfg_r.image_height);
      default:                    cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/color_key_run_extractor_core.sv -----
// color_key_run_extractor_core: top level of the color-key run extractor.
// Compares raster pixels with a key color and emits opaque runs per row.
// Depends on ckre_pkg and ckre_cfg_regs.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_      | slave     | tuser: kind; tdata: pixel_value, palette_index,
//            |           |   entry_value
//   out_     | master    | tdata: run_row, run_left, run_right
//   cfg_     | APB slave | key_color, pixel_format, image_width, image_height
//
// One word per clock while the result is not stalled: a word is taken into
// a pixel register (palette read happens on the same edge), the compare and
// run update sit between that register and the result register, which
// drives out_tvalid. Palette writes land in the palette on the edge they
// are accepted and produce no result. Reset (synchronous, rst_n low) clears
// position, run state and valid flags; palette contents stay undefined.
// A stalled result holds the pixel register; input is taken again as soon
// as the pixel register drains.
module color_key_run_extractor_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [31:0] pixel_value, [39:32] palette_index,
                                  // [71:40] entry_value
  input  logic        in_tuser,   // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] run_row, [23:12] run_left,
                                  // [36:24] run_right, [39:37] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW   = $clog2(PALETTE_DEPTH);
  localparam int WDW  = $clog2(MAX_WIDTH + 1);
  localparam int HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = ((WDW > ckre_pkg::SIZE_W) ? WDW : ckre_pkg::SIZE_W) + 1;
  localparam int HCMP = ((HDW > ckre_pkg::SIZE_W) ? HDW : ckre_pkg::SIZE_W) + 1;

  ckre_pkg::cfg_t cfg;

  ckre_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // ---------------------------------------------------------------- input
  logic        in_kind;
  logic [31:0] in_pixel;
  logic [7:0]  in_pal_idx;
  logic [31:0] in_entry;
  logic        in_acc;
  logic        in_idx_ok;

  assign in_kind    = in_tuser;
  assign in_pixel   = in_tdata[31:0];
  assign in_pal_idx = in_tdata[39:32];
  assign in_entry   = in_tdata[71:40];
  assign in_acc     = in_tvalid && in_tready;
  assign in_idx_ok  = 9'(in_pal_idx) < 9'(PALETTE_DEPTH);

  // Palette: written on accept of a palette word, read on accept of a pixel.
  logic [31:0]   pal_mem [PALETTE_DEPTH];
  logic [31:0]   pal_rd_r;
  logic [AW-1:0] in_pal_idx_rd;

  assign in_pal_idx_rd = in_pixel[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == ckre_pkg::KIND_PAL_WRITE) && in_idx_ok) begin
      pal_mem[in_pal_idx[AW-1:0]] <= in_entry;
    end
    if (in_acc && (in_kind == ckre_pkg::KIND_PIXEL)) begin
      pal_rd_r <= pal_mem[in_pal_idx_rd];
    end
  end

  // ------------------------------------------------------- pixel register
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_pixel_r;
  logic        s1_oor_r;     // pixel index beyond palette depth
  logic        s1_adv;
  logic        out_valid_r, out_valid_nxt;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = (in_kind == ckre_pkg::KIND_PIXEL);
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == ckre_pkg::KIND_PIXEL)) begin
      s1_pixel_r <= in_pixel;
      s1_oor_r   <= !(9'(in_pixel[7:0]) < 9'(PALETTE_DEPTH));
    end
  end

  // ------------------------------------------------------------ compare
  logic [7:0]  key_r8, key_g8, key_b8;
  logic [23:0] key_rgb;
  logic [15:0] key_565;
  logic [31:0] pal_color;
  logic        opaque;

  assign key_r8  = cfg.key_color[7:0];
  assign key_g8  = cfg.key_color[15:8];
  assign key_b8  = cfg.key_color[23:16];
  assign key_rgb = {key_r8, key_g8, key_b8};
  assign key_565 = {key_r8[7:3], key_g8[7:2], key_b8[7:3]};
  assign pal_color = s1_oor_r ? 32'd0 : pal_rd_r;

  always_comb begin
    case (cfg.pixel_format)
      ckre_pkg::FMT_PAL8:  opaque = pal_color != 32'(key_rgb);
      ckre_pkg::FMT_RGB16: opaque = s1_pixel_r[15:0] != key_565;
      ckre_pkg::FMT_RGB24: opaque = s1_pixel_r[23:0] != key_rgb;
      default:             opaque = s1_pixel_r != 32'(key_rgb);
    endcase
  end

  // ---------------------------------------------------------- size clamp
  logic [WCMP-1:0] w_raw, w_eff;
  logic [HCMP-1:0] h_raw, h_eff;

  assign w_raw = WCMP'(cfg.image_width);
  assign h_raw = HCMP'(cfg.image_height);

  always_comb begin
    if (w_raw == '0)                    w_eff = WCMP'(1);
    else if (w_raw > WCMP'(MAX_WIDTH))  w_eff = WCMP'(MAX_WIDTH);
    else                                w_eff = w_raw;
    if (h_raw == '0)                    h_eff = HCMP'(1);
    else if (h_raw > HCMP'(MAX_HEIGHT)) h_eff = HCMP'(MAX_HEIGHT);
    else                                h_eff = h_raw;
  end

  // ----------------------------------------------------------- run state
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic            in_run_r, in_run_nxt;
  logic [CW-1:0]   start_r, start_nxt;
  logic [WCMP-1:0] j_plus1;
  logic [HCMP-1:0] row_plus1;
  logic            row_end;
  logic            emit_key;   // key pixel closes an open run
  logic            emit_eol;   // row end closes an open run
  logic            run_open;

  assign j_plus1   = WCMP'(col_r) + WCMP'(1);
  assign row_plus1 = HCMP'(row_r) + HCMP'(1);
  assign row_end   = j_plus1 >= w_eff;
  assign emit_key  = in_run_r && !opaque;
  assign run_open  = opaque;   // continuing or freshly started
  assign emit_eol  = row_end && run_open;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    in_run_nxt = in_run_r;
    start_nxt  = start_r;
    if (s1_adv) begin
      if (!in_run_r && opaque) begin
        start_nxt = col_r;
      end
      if (row_end) begin
        in_run_nxt = 1'b0;
        col_nxt    = '0;
        row_nxt    = (row_plus1 >= h_eff) ? '0 : RW'(row_plus1);
      end else begin
        in_run_nxt = run_open;
        col_nxt    = CW'(j_plus1);
      end
    end
  end

  // ------------------------------------------------------- result register
  logic [11:0] res_row_r, res_left_r;
  logic [12:0] res_right_r;
  logic [31:0] row_ext, left_ext, right_ext;

  assign row_ext   = 32'(row_r);
  assign left_ext  = emit_key ? 32'(start_r) : 32'(start_nxt);
  assign right_ext = emit_key ? 32'(col_r)   : 32'(j_plus1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = emit_key || emit_eol;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      in_run_r    <= 1'b0;
      start_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      in_run_r    <= in_run_nxt;
      start_r     <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (emit_key || emit_eol)) begin
      res_row_r   <= row_ext[11:0];
      res_left_r  <= left_ext[11:0];
      res_right_r <= right_ext[12:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_right_r, res_left_r, res_row_r};

  // ------------------------------------------------------------ checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pixel register is stalled");

  a_row_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && row_end) |=> (col_r == '0 && !in_run_r))
    else $error("row end did not clear column and run state");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, res_left_r} < res_right_r))
    else $error("emitted run is empty");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> !(emit_key && emit_eol))
    else $error("two results from one pixel");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for color_key_run_extractor_core.
// Drives pixel and palette words, predicts the opaque runs and checks each result word.
// Depends on ckre_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;    // settle time after the last predicted run has returned; keep margin
  localparam int MAX_W        = 4096;
  localparam int MAX_H        = 4096;

  typedef struct {
    logic [11:0] row;
    logic [11:0] left;
    logic [12:0] right;
  } run_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // [31:0] pixel_value, [39:32] palette_index, [71:40] entry_value
  logic        in_tuser = 1'b0; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [11:0] run_row, [23:12] run_left, [36:24] run_right
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the registers and the raster state.
  logic [23:0] key_reg = ckre_pkg::KEY_RESET;
  logic [1:0]  fmt_reg = ckre_pkg::FMT_RESET;
  logic [12:0] width_reg = ckre_pkg::WIDTH_RESET;
  logic [12:0] height_reg = ckre_pkg::HEIGHT_RESET;
  logic [11:0] col_pos = '0;
  logic [11:0] row_pos = '0;
  logic        run_open = 1'b0;
  logic [11:0] run_first = '0;
  logic [31:0] palette_mem [256];
  logic [7:0]  pal_loaded [$];    // entries written so far; only these may be looked up
  bit          pal_seen [256];

  run_t        pending_runs [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 58;
  int          hold_cycles = 0;

  color_key_run_extractor_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off completely while hold_cycles runs down.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result word with the oldest predicted run.
  always @(posedge clk) begin
    run_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run word: row %0d left %0d right %0d",
               out_tdata[11:0], out_tdata[23:12], out_tdata[36:24]);
        fail_count++;
      end else begin
        want = pending_runs.pop_front();
        if (out_tdata[11:0] !== want.row) begin
          $error("run_row mismatch: expected %0d, actual %0d", want.row, out_tdata[11:0]);
          fail_count++;
        end
        if (out_tdata[23:12] !== want.left) begin
          $error("run_left mismatch: expected %0d, actual %0d", want.left, out_tdata[23:12]);
          fail_count++;
        end
        if (out_tdata[36:24] !== want.right) begin
          $error("run_right mismatch: expected %0d, actual %0d", want.right, out_tdata[36:24]);
          fail_count++;
        end
      end
    end
  end

  // Key as 0x00RRGGBB, the way pixels carry it.
  function automatic logic [31:0] swapped_key();
    return {8'h00, key_reg[7:0], key_reg[15:8], key_reg[23:16]};
  endfunction

  // Key packed to 5:6:5.
  function automatic logic [15:0] key_565();
    return {key_reg[7:3], key_reg[15:10], key_reg[23:19]};
  endfunction

  function automatic logic pixel_opaque(logic [31:0] px);
    case (fmt_reg)
      ckre_pkg::FMT_PAL8:  return palette_mem[px[7:0]] != swapped_key();
      ckre_pkg::FMT_RGB16: return px[15:0] != key_565();
      ckre_pkg::FMT_RGB24: return {8'h00, px[23:0]} != swapped_key();
      default:             return px != swapped_key();
    endcase
  endfunction

  function automatic logic [12:0] clamp_dim(logic [12:0] v, int lim);
    if (v == 0) return 13'd1;
    if (v > lim) return 13'(lim);
    return v;
  endfunction

  // Advance the raster model by one accepted word and queue the run it closes, if any.
  task automatic predict_runs(logic kind, logic [31:0] px, logic [7:0] idx, logic [31:0] entry);
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] next_col;
    logic        opaque;
    run_t        closed;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (kind == ckre_pkg::KIND_PAL_WRITE) begin
      palette_mem[idx] = entry;
      if (!pal_seen[idx]) begin
        pal_seen[idx] = 1'b1;
        pal_loaded = {pal_loaded, idx};
      end
      return;
    end
    opaque = pixel_opaque(px);
    next_col = {1'b0, col_pos} + 13'd1;
    closed.row = row_pos;
    closed.left = run_first;
    if (run_open && !opaque) begin
      // key pixel closes the run just before it
      closed.right = {1'b0, col_pos};
      pending_runs = {pending_runs, closed};
      run_open = 1'b0;
    end else if (!run_open && opaque) begin
      run_first = col_pos;
      closed.left = col_pos;
      run_open = 1'b1;
    end
    if (next_col >= w) begin
      // row end flushes an open run
      if (run_open) begin
        closed.right = next_col;
        pending_runs = {pending_runs, closed};
        run_open = 1'b0;
      end
      col_pos = '0;
      row_pos = ({1'b0, row_pos} + 13'd1 >= h) ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = next_col[11:0];
    end
  endtask

  // Offer one word after a random gap; hold it until taken, then predict.
  task automatic send_word(logic kind, logic [31:0] px, logic [7:0] idx, logic [31:0] entry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {entry, idx, px};
    do @(posedge clk); while (!in_tready);
    predict_runs(kind, px, idx, entry);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_pixel(logic [31:0] px);
    send_word(ckre_pkg::KIND_PIXEL, px, 8'($urandom), $urandom);
  endtask

  task automatic send_palette(logic [7:0] idx, logic [31:0] entry);
    send_word(ckre_pkg::KIND_PAL_WRITE, $urandom, idx, entry);
  endtask

  // Build a pixel that matches the key, or a random one; unused high bits stay random.
  function automatic logic [31:0] make_pixel(bit as_key);
    logic [31:0] raw;
    logic [7:0]  hits [$];
    raw = $urandom;
    case (fmt_reg)
      ckre_pkg::FMT_PAL8: begin
        if (as_key)
          foreach (pal_loaded[k])
            if (palette_mem[pal_loaded[k]] == swapped_key()) hits = {hits, pal_loaded[k]};
        if (hits.size() != 0) raw[7:0] = hits[$urandom_range(hits.size() - 1)];
        else raw[7:0] = pal_loaded[$urandom_range(pal_loaded.size() - 1)];
      end
      ckre_pkg::FMT_RGB16: if (as_key) raw[15:0] = key_565();
      ckre_pkg::FMT_RGB24: if (as_key) raw[23:0] = 24'(swapped_key());
      default:             if (as_key) raw = swapped_key();
    endcase
    return raw;
  endfunction

  // Block until every predicted run has come back, then let the pipe empty.
  task automatic wait_idle();
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(ckre_pkg::reg_idx_t r, logic [31:0] v);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {r, 2'b00};
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      ckre_pkg::REG_KEY_COLOR:    key_reg = v[23:0];
      ckre_pkg::REG_PIXEL_FORMAT: fmt_reg = v[1:0];
      ckre_pkg::REG_IMAGE_WIDTH:  width_reg = v[12:0];
      ckre_pkg::REG_IMAGE_HEIGHT: height_reg = v[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Reprogram all four registers once the block has gone quiet.
  task automatic program_frame(logic [23:0] key, logic [1:0] fmt, logic [12:0] w, logic [12:0] h);
    wait_idle();
    cfg_write(ckre_pkg::REG_KEY_COLOR, {8'h00, key});
    cfg_write(ckre_pkg::REG_PIXEL_FORMAT, {30'd0, fmt});
    cfg_write(ckre_pkg::REG_IMAGE_WIDTH, {19'd0, w});
    cfg_write(ckre_pkg::REG_IMAGE_HEIGHT, {19'd0, h});
  endtask

  // Change idling on the rising edge so the receiver reads it cleanly on the next fall.
  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  // Reset values: magenta key in 24-bit mode; the high byte must be ignored.
  task automatic test_reset_defaults();
    send_pixel(32'h0000_0001);
    send_pixel(32'hAB_FF00FF);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_00FF);
  endtask

  // Key handling in every direct-color format; red/blue swap of the key in 32-bit mode.
  task automatic test_key_formats();
    program_frame(24'h563412, ckre_pkg::FMT_RGB32, 13'd6, 13'd3);
    send_pixel(32'h0012_3456);   // key
    send_pixel(32'h0112_3456);   // high byte counts in 32-bit mode
    send_pixel(32'h0056_3412);   // unswapped key is opaque
    send_pixel(32'h0012_3456);
    program_frame(24'hFFFFFF, ckre_pkg::FMT_RGB16, 13'd3, 13'd2);
    send_pixel(32'h0000_FFFE);
    send_pixel(32'hABCD_FFFF);   // key in 5:6:5, high half ignored
    send_pixel(32'h0000_0000);
    program_frame(24'h000000, ckre_pkg::FMT_RGB24, 13'd2, 13'd2);
    send_pixel(32'hFF00_0000);   // key, top byte ignored
    send_pixel(32'h0000_0001);
  endtask

  // Palette lookup: key entry, all-ones entry, and an entry that differs only above bit 23.
  task automatic test_palette();
    program_frame(24'h00AA55, ckre_pkg::FMT_PAL8, 13'd4, 13'd2);
    send_palette(8'd0, swapped_key());
    send_palette(8'd255, 32'hFFFF_FFFF);
    send_palette(8'd7, swapped_key() | 32'h0100_0000);
    send_pixel(($urandom & 32'hFFFF_FF00) | 32'd255);
    send_pixel(($urandom & 32'hFFFF_FF00) | 32'd7);
    send_pixel(($urandom & 32'hFFFF_FF00) | 32'd0);
    send_pixel(($urandom & 32'hFFFF_FF00) | 32'd7);
  endtask

  // Zero sizes count as one, oversize counts as the maximum.
  task automatic test_size_clamp();
    program_frame(24'hFFFFFF, ckre_pkg::FMT_RGB24, 13'd0, 13'd0);
    send_pixel(32'h0000_0123);
    send_pixel(32'h00FF_FFFF);
    program_frame(24'hFFFFFF, ckre_pkg::FMT_RGB24, 13'd8191, 13'd8191);
    send_pixel(32'h0000_0005);
    send_pixel(32'h0000_0006);
  endtask

  // Hold the receiver off long enough for the core to back up and stall its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    program_frame(24'h00FF00, ckre_pkg::FMT_RGB24, 13'd5, 13'd3);
    @(posedge clk);
    hold_cycles = 200;
    @(negedge clk);
    repeat (40) send_pixel(make_pixel($urandom_range(99) < 40));
    wait_idle();
  endtask

  // Random frames: random key, format and size per batch, pixel content biased toward runs.
  task automatic test_random_stream(int send_pct, int recv_pct, int n_pixels);
    int          px_done;
    int          key_pct;
    int          pick;
    logic [23:0] key;
    logic [1:0]  fmt;
    logic [12:0] w;
    logic [12:0] h;
    set_idling(send_pct, recv_pct);
    px_done = 0;
    while (px_done < n_pixels) begin
      pick = $urandom_range(9);
      key = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
      fmt = 2'($urandom_range(3));
      pick = $urandom_range(19);
      if (pick < 14) w = 13'($urandom_range(1, 24));
      else if (pick < 18) w = 13'($urandom_range(25, 300));
      else if (pick == 18) w = 13'd4096;
      else w = ($urandom_range(1) != 0) ? 13'd0 : 13'($urandom_range(4097, 8191));
      pick = $urandom_range(19);
      if (pick < 17) h = 13'($urandom_range(1, 6));
      else if (pick == 17) h = 13'd4096;
      else if (pick == 18) h = 13'd0;
      else h = 13'($urandom_range(4097, 8191));
      program_frame(key, fmt, w, h);
      // load the palette; the key entry goes last so a lookup can hit it
      if (fmt == ckre_pkg::FMT_PAL8 || $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_palette(8'($urandom), $urandom);
        send_palette(8'($urandom), swapped_key());
      end
      key_pct = $urandom_range(10, 60);
      repeat ($urandom_range(30, 90)) begin
        if ($urandom_range(99) < 3) begin
          send_palette(8'($urandom), ($urandom_range(1) != 0) ? swapped_key() : $urandom);
        end else begin
          send_pixel(make_pixel($urandom_range(99) < key_pct));
          px_done++;
        end
      end
    end
  endtask

  initial begin
    foreach (palette_mem[k]) palette_mem[k] = '0;
    foreach (pal_seen[k]) pal_seen[k] = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_key_formats();
    test_palette();
    test_size_clamp();
    test_backpressure();
    test_random_stream(31, 58, 360);
    test_random_stream(58, 31, 360);
    test_random_stream(0, 0, 360);

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ckre_pkg.sv
rtl/ckre_cfg_regs.sv
rtl/color_key_run_extractor_core.sv
tb/tb.sv
